// ----- rtl/core/epbp_pkg.sv -----
// Package for the extreme point box placer.
// Holds default sizes, register indexes and point-list codes; no dependencies.
package epbp_pkg;

	// Default sizing of the placer
	localparam int MAX_BOXES_DEF  = 64;
	localparam int COORD_BITS_DEF = 15;

	// Configuration register indexes
	localparam logic [1:0] REG_CONT_LENGTH = 2'd0;
	localparam logic [1:0] REG_CONT_WIDTH  = 2'd1;
	localparam logic [1:0] REG_CONT_HEIGHT = 2'd2;

	// Point list codes, also the upper address bits of the point memory
	localparam logic [1:0] LST_WIDTH  = 2'd0;
	localparam logic [1:0] LST_HEIGHT = 2'd1;
	localparam logic [1:0] LST_LENGTH = 2'd2;

	// Index of the last orientation tried per box, counted from zero
	localparam logic [2:0] LAST_ORIENT = 3'd6;

endpackage

// ----- rtl/core/epbp_ram.sv -----
// Simple dual port RAM: one write port, one read port with registered data.
// Used for the placed-box table and the extreme point lists; no dependencies.
module epbp_ram #(
	parameter int WIDTH = 90,
	parameter int ABITS = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ABITS-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [ABITS-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [2**ABITS];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/extreme_point_box_placer.sv -----
// Top level of the extreme point box placer: sequencer, container registers, counters.
// Depends on epbp_pkg and epbp_ram.
//
// Channel   | Signals                                      | Handshake
// ----------+----------------------------------------------+-------------------------
// box in    | start, busy, box_length/width/height         | start & !busy
// result    | done, placed, pos_*, size_*, boxes_held      | done strobe, one cycle
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data    | cfg_valid & cfg_ready
//
// The first box goes through S_PLACE and the append states straight to its result; a
// box that meets a full table gets its result in the cycle after the request. Otherwise
// each candidate point is read, fit-tested and checked against the held boxes in turn,
// as the single read port of the box table streams one box per cycle; removing the
// chosen point takes a read and a write state for each later point in its list.
// Reset clears counters and sets the container registers to all ones.
// The receiver cannot stall: each result is shown for one cycle with done high.
module extreme_point_box_placer #(
	parameter int MAX_BOXES  = epbp_pkg::MAX_BOXES_DEF,
	parameter int COORD_BITS = epbp_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [COORD_BITS-1:0]               box_length,
	input  logic [COORD_BITS-1:0]               box_width,
	input  logic [COORD_BITS-1:0]               box_height,
	output logic                                done,
	output logic                                placed,
	output logic [COORD_BITS-1:0]               pos_l,
	output logic [COORD_BITS-1:0]               pos_w,
	output logic [COORD_BITS-1:0]               pos_h,
	output logic [COORD_BITS-1:0]               size_l,
	output logic [COORD_BITS-1:0]               size_w,
	output logic [COORD_BITS-1:0]               size_h,
	output logic [$clog2(MAX_BOXES+1)-1:0]      boxes_held,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data
);

	import epbp_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int CW = $clog2(MAX_BOXES + 1);
	localparam int IB = $clog2(MAX_BOXES);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PT_RD  = 4'd1;
	localparam logic [3:0] S_PT_CHK = 4'd2;
	localparam logic [3:0] S_BX     = 4'd3;
	localparam logic [3:0] S_DEL_RD = 4'd4;
	localparam logic [3:0] S_DEL_WR = 4'd5;
	localparam logic [3:0] S_PLACE  = 4'd6;
	localparam logic [3:0] S_AP_W   = 4'd7;
	localparam logic [3:0] S_AP_H   = 4'd8;
	localparam logic [3:0] S_AP_L   = 4'd9;

	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BOXES);
	localparam logic [CW-1:0] CNT_ONE = CW'(1);

	logic [3:0]    state_q;
	logic [CB-1:0] cont_l_q, cont_w_q, cont_h_q;
	logic [CW-1:0] box_cnt_q, wcnt_q, hcnt_q, lcnt_q;
	logic [CW-1:0] idx_q, bx_rd_q;
	logic [1:0]    list_q;
	logic [2:0]    orient_q;
	logic          rv_q, last_q;
	logic          done_q;
	logic [CB-1:0] gl_q, gw_q, gh_q;
	logic [CB-1:0] sl_q, sw_q, sh_q;
	logic [CB-1:0] pl_q, pw_q, ph_q;
	logic [CB-1:0] ol_q, ow_q, oh_q, osl_q, osw_q, osh_q;
	logic          oplaced_q;
	logic [CW-1:0] oheld_q;

	// Memory ports
	logic               pt_we, bx_we;
	logic [IB+1:0]      pt_waddr, pt_raddr;
	logic [3*CB-1:0]    pt_wdata, pt_rdata;
	logic [IB-1:0]      bx_waddr, bx_raddr;
	logic [6*CB-1:0]    bx_wdata, bx_rdata;

	epbp_ram #(.WIDTH(3*CB), .ABITS(IB+2)) u_pt_ram (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata)
	);

	epbp_ram #(.WIDTH(6*CB), .ABITS(IB)) u_bx_ram (
		.clk(clk), .we(bx_we), .waddr(bx_waddr), .wdata(bx_wdata),
		.raddr(bx_raddr), .rdata(bx_rdata)
	);

	// Half-open interval intersection along one axis.
	function automatic logic meets(input logic [CB-1:0] a, input logic [CB-1:0] al,
			input logic [CB-1:0] b, input logic [CB-1:0] bl);
		logic [CB:0] ae, be;
		begin
			ae = {1'b0, a} + {1'b0, al};
			be = {1'b0, b} + {1'b0, bl};
			meets = ((a >= b) && ({1'b0, a} < be)) || ((b >= a) && ({1'b0, b} < ae));
		end
	endfunction

	// Count of the list under scan.
	logic [CW-1:0] cur_cnt;
	always_comb begin
		case (list_q)
			LST_WIDTH:  cur_cnt = wcnt_q;
			LST_HEIGHT: cur_cnt = hcnt_q;
			LST_LENGTH: cur_cnt = lcnt_q;
			default:    cur_cnt = '0;
		endcase
	end

	// Fit test of the fetched point against the container.
	logic [CB-1:0] ptl, ptw, pth;
	logic          fits;
	assign ptl = pt_rdata[3*CB-1:2*CB];
	assign ptw = pt_rdata[2*CB-1:CB];
	assign pth = pt_rdata[CB-1:0];
	assign fits = (({1'b0, ptl} + {1'b0, sl_q}) < {1'b0, cont_l_q}) &&
	              (({1'b0, ptw} + {1'b0, sw_q}) < {1'b0, cont_w_q}) &&
	              (({1'b0, pth} + {1'b0, sh_q}) < {1'b0, cont_h_q});

	// Overlap test of the candidate against the streamed box.
	logic overlap;
	assign overlap = meets(pl_q, sl_q, bx_rdata[6*CB-1:5*CB], bx_rdata[3*CB-1:2*CB]) &&
	                 meets(pw_q, sw_q, bx_rdata[5*CB-1:4*CB], bx_rdata[2*CB-1:CB]) &&
	                 meets(ph_q, sh_q, bx_rdata[4*CB-1:3*CB], bx_rdata[CB-1:0]);

	logic [CW-1:0] idx_nx;
	assign idx_nx = idx_q + CNT_ONE;

	// Memory address and write steering.
	always_comb begin
		pt_raddr = {list_q, idx_q[IB-1:0]};
		if (state_q == S_DEL_RD) begin
			pt_raddr = {list_q, idx_nx[IB-1:0]};
		end
		pt_we    = 1'b0;
		pt_waddr = {list_q, idx_q[IB-1:0]};
		pt_wdata = pt_rdata;
		case (state_q)
			S_DEL_WR: begin
				pt_we = 1'b1;
			end
			S_AP_W: begin
				pt_we    = wcnt_q < CNT_MAX;
				pt_waddr = {LST_WIDTH, wcnt_q[IB-1:0]};
				pt_wdata = {pl_q, pw_q + sw_q, ph_q};
			end
			S_AP_H: begin
				pt_we    = hcnt_q < CNT_MAX;
				pt_waddr = {LST_HEIGHT, hcnt_q[IB-1:0]};
				pt_wdata = {pl_q, pw_q, ph_q + sh_q};
			end
			S_AP_L: begin
				pt_we    = lcnt_q < CNT_MAX;
				pt_waddr = {LST_LENGTH, lcnt_q[IB-1:0]};
				pt_wdata = {pl_q + sl_q, pw_q, ph_q};
			end
			default: begin
			end
		endcase
		bx_raddr = bx_rd_q[IB-1:0];
		bx_we    = state_q == S_PLACE;
		bx_waddr = box_cnt_q[IB-1:0];
		bx_wdata = {pl_q, pw_q, ph_q, sl_q, sw_q, sh_q};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_l_q <= '1;
			cont_w_q <= '1;
			cont_h_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CONT_LENGTH: cont_l_q <= cfg_data;
				REG_CONT_WIDTH:  cont_w_q <= cfg_data;
				REG_CONT_HEIGHT: cont_h_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			box_cnt_q <= '0;
			wcnt_q    <= '0;
			hcnt_q    <= '0;
			lcnt_q    <= '0;
			idx_q     <= '0;
			bx_rd_q   <= '0;
			list_q    <= LST_WIDTH;
			orient_q  <= '0;
			rv_q      <= 1'b0;
			last_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q    <= '0;
						list_q   <= LST_WIDTH;
						orient_q <= '0;
						if (box_cnt_q == '0) begin
							state_q <= S_PLACE;
						end else if (box_cnt_q >= CNT_MAX) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_PT_RD;
						end
					end
				end
				S_PT_RD: begin
					if (idx_q < cur_cnt) begin
						state_q <= S_PT_CHK;
					end else if (list_q != LST_LENGTH) begin
						list_q <= list_q + 2'd1;
						idx_q  <= '0;
					end else if (orient_q == LAST_ORIENT) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						orient_q <= orient_q + 3'd1;
						list_q   <= LST_WIDTH;
						idx_q    <= '0;
					end
				end
				S_PT_CHK: begin
					rv_q    <= 1'b0;
					bx_rd_q <= '0;
					if (fits) begin
						state_q <= S_BX;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_PT_RD;
					end
				end
				S_BX: begin
					// Stream one held box per cycle through the overlap test.
					rv_q    <= bx_rd_q < box_cnt_q;
					last_q  <= (bx_rd_q + CNT_ONE) == box_cnt_q;
					bx_rd_q <= bx_rd_q + CNT_ONE;
					if (rv_q && overlap) begin
						rv_q    <= 1'b0;
						idx_q   <= idx_nx;
						state_q <= S_PT_RD;
					end else if (rv_q && last_q) begin
						state_q <= S_DEL_RD;
					end
				end
				S_DEL_RD: begin
					// Close the gap left by the taken point.
					if (idx_nx < cur_cnt) begin
						state_q <= S_DEL_WR;
					end else begin
						case (list_q)
							LST_WIDTH:  wcnt_q <= wcnt_q - CNT_ONE;
							LST_HEIGHT: hcnt_q <= hcnt_q - CNT_ONE;
							default:    lcnt_q <= lcnt_q - CNT_ONE;
						endcase
						state_q <= S_PLACE;
					end
				end
				S_DEL_WR: begin
					idx_q   <= idx_nx;
					state_q <= S_DEL_RD;
				end
				S_PLACE: begin
					box_cnt_q <= box_cnt_q + CNT_ONE;
					state_q   <= S_AP_W;
				end
				S_AP_W: begin
					if (wcnt_q < CNT_MAX) wcnt_q <= wcnt_q + CNT_ONE;
					state_q <= S_AP_H;
				end
				S_AP_H: begin
					if (hcnt_q < CNT_MAX) hcnt_q <= hcnt_q + CNT_ONE;
					state_q <= S_AP_L;
				end
				S_AP_L: begin
					if (lcnt_q < CNT_MAX) lcnt_q <= lcnt_q + CNT_ONE;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Box sizes, candidate point and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					gl_q <= box_length;
					gw_q <= box_width;
					gh_q <= box_height;
					sl_q <= box_length;
					sw_q <= box_width;
					sh_q <= box_height;
					pl_q <= '0;
					pw_q <= '0;
					ph_q <= '0;
					if (box_cnt_q >= CNT_MAX) begin
						oplaced_q <= 1'b0;
						ol_q      <= '0;
						ow_q      <= '0;
						oh_q      <= '0;
						osl_q     <= box_length;
						osw_q     <= box_width;
						osh_q     <= box_height;
						oheld_q   <= box_cnt_q;
					end
				end
			end
			S_PT_RD: begin
				if (!(idx_q < cur_cnt) && list_q == LST_LENGTH) begin
					if (orient_q == LAST_ORIENT) begin
						oplaced_q <= 1'b0;
						ol_q      <= '0;
						ow_q      <= '0;
						oh_q      <= '0;
						osl_q     <= gl_q;
						osw_q     <= gw_q;
						osh_q     <= gh_q;
						oheld_q   <= box_cnt_q;
					end else if (!orient_q[0]) begin
						sl_q <= sw_q;
						sw_q <= sl_q;
					end else begin
						sw_q <= sh_q;
						sh_q <= sw_q;
					end
				end
			end
			S_PT_CHK: begin
				pl_q <= ptl;
				pw_q <= ptw;
				ph_q <= pth;
			end
			S_AP_L: begin
				oplaced_q <= 1'b1;
				ol_q      <= pl_q;
				ow_q      <= pw_q;
				oh_q      <= ph_q;
				osl_q     <= sl_q;
				osw_q     <= sw_q;
				osh_q     <= sh_q;
				oheld_q   <= box_cnt_q;
			end
			default: begin
			end
		endcase
	end

	assign busy       = state_q != S_IDLE;
	assign cfg_ready  = 1'b1;
	assign done       = done_q;
	assign placed     = oplaced_q;
	assign pos_l      = ol_q;
	assign pos_w      = ow_q;
	assign pos_h      = oh_q;
	assign size_l     = osl_q;
	assign size_w     = osw_q;
	assign size_h     = osh_q;
	assign boxes_held = oheld_q;

endmodule
